FILE: hw/rtl/csv_byte_tokenizer_top_defines.svh
// Assertion macros for the CSV byte tokenizer.
// Included by csv_byte_tokenizer_top; expects clk_i and rst_ni in scope.
`ifndef CSV_BYTE_TOKENIZER_TOP_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CSVT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CSVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSVT_ASSERT(name, prop, msg)
`define CSVT_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/csvt_pkg.sv
// Types, constants and the per-byte tokenizer step of the CSV byte tokenizer.
// Used by csv_byte_tokenizer_top.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = 3;
  localparam int unsigned SlotW      = 2;

  // Configuration register indexes.
  localparam logic [1:0] RegDelimiter = 2'd0;
  localparam logic [1:0] RegQuote     = 2'd1;
  localparam logic [1:0] RegSkipBom   = 2'd2;

  localparam logic [7:0] DelimReset = 8'h2C;
  localparam logic [7:0] QuoteReset = 8'h22;

  localparam logic [7:0] BomB0 = 8'hEF;
  localparam logic [7:0] BomB1 = 8'hBB;
  localparam logic [7:0] BomB2 = 8'hBF;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;

  // Byte-order mark progress.
  localparam logic [1:0] BomNone = 2'd0;
  localparam logic [1:0] BomOne  = 2'd1;
  localparam logic [1:0] BomTwo  = 2'd2;
  localparam logic [1:0] BomDone = 2'd3;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic after_cr;
    logic row_open;
  } state_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       has_byte;
    logic       end_of_field;
    logic       end_of_row;
  } res_t;

  typedef struct packed {
    state_t st;
    logic   emit;
    res_t   res;
  } tok_t;

  // One tokenizer step for a single byte: at most one result.
  function automatic tok_t tok_step(state_t s, logic [7:0] delim, logic [7:0] quote,
                                    logic [7:0] c);
    tok_t t;
    logic done;
    t      = '0;
    t.st   = s;
    done   = 1'b0;
    if (s.quote_pending) begin
      t.st.quote_pending = 1'b0;
      if (c == quote) begin
        t.emit = 1'b1;
        t.res  = '{field_byte: quote, has_byte: 1'b1, end_of_field: 1'b0, end_of_row: 1'b0};
        done   = 1'b1;
      end else begin
        t.st.in_quotes = 1'b0;
      end
    end
    if (!done && t.st.after_cr) begin
      t.st.after_cr = 1'b0;
      if (c == ChLf) begin
        done = 1'b1;
      end
    end
    if (!done) begin
      if (t.st.in_quotes) begin
        t.st.row_open = 1'b1;
        if (c == quote) begin
          t.st.quote_pending = 1'b1;
        end else begin
          t.emit = 1'b1;
          t.res  = '{field_byte: c, has_byte: 1'b1, end_of_field: 1'b0, end_of_row: 1'b0};
        end
      end else if (c == quote) begin
        t.st.in_quotes = 1'b1;
        t.st.row_open  = 1'b1;
      end else if (c == delim) begin
        t.st.row_open = 1'b1;
        t.emit = 1'b1;
        t.res  = '{field_byte: 8'h00, has_byte: 1'b0, end_of_field: 1'b1, end_of_row: 1'b0};
      end else if (c == ChCr) begin
        t.st.row_open = 1'b0;
        t.st.after_cr = 1'b1;
        t.emit = 1'b1;
        t.res  = '{field_byte: 8'h00, has_byte: 1'b0, end_of_field: 1'b1, end_of_row: 1'b1};
      end else if (c == ChLf) begin
        t.st.row_open = 1'b0;
        t.emit = 1'b1;
        t.res  = '{field_byte: 8'h00, has_byte: 1'b0, end_of_field: 1'b1, end_of_row: 1'b1};
      end else begin
        t.st.row_open = 1'b1;
        t.emit = 1'b1;
        t.res  = '{field_byte: c, has_byte: 1'b1, end_of_field: 1'b0, end_of_row: 1'b0};
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csvt_in_if.sv
// Input byte channel of the CSV byte tokenizer: valid/ready plus raw byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvt_out_if.sv
// Result channel of the CSV byte tokenizer: valid/ready plus token fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_byte;
  logic       has_byte;
  logic       end_of_field;
  logic       end_of_row;
  logic       last_of_run;

  modport source (output valid, output field_byte, output has_byte, output end_of_field,
                  output end_of_row, output last_of_run, input ready);
  modport sink   (input valid, input field_byte, input has_byte, input end_of_field,
                  input end_of_row, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvt_cfg_if.sv
// Configuration write channel of the CSV byte tokenizer: register index and data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csv_byte_tokenizer_top.sv
// CSV byte tokenizer: byte-order mark stripping, quoting, row and field marks.
// Depends on csvt_pkg, the csvt_*_if interfaces and the assertion macro header.
// Latency: the first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte gives at most one result and the output is
// ready; a byte giving several results holds the input until the last of them is being taken.
// Reset clears tokenizer state, the result count and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "csv_byte_tokenizer_top_defines.svh"

module csv_byte_tokenizer_top (
  input  wire     clk_i,
  input  wire     rst_ni,
  csvt_in_if.sink   in_i,
  csvt_out_if.source out_o,
  csvt_cfg_if.sink  cfg_i
);
  import csvt_pkg::*;

  logic [7:0] delim_q, quote_q;
  logic       skip_bom_q;
  state_t     st_q, st_d;
  logic [1:0] bom_q, bom_d;

  res_t             res_q [MaxResults];
  res_t             res_d [MaxResults];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0] head_q;

  logic in_fire, out_fire;

  tok_t       t_b0, t_b1, t_c;
  logic       match, flush, flush_b0, flush_b1;
  logic [1:0] phase_eff;
  logic [7:0] want;
  res_t       cand [MaxResults];
  logic       cand_emit [MaxResults];
  logic       close_row;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= DelimReset;
      quote_q    <= QuoteReset;
      skip_bom_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDelimiter: delim_q    <= cfg_i.data;
        RegQuote:     quote_q    <= cfg_i.data;
        RegSkipBom:   skip_bom_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // The buffer only ever holds results of one byte, so a new byte may enter once
  // the last of them is being taken.
  assign out_fire    = out_o.valid && out_o.ready;
  assign in_i.ready  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;

  always_comb begin
    unique case (bom_q)
      BomNone: want = BomB0;
      BomOne:  want = BomB1;
      default: want = BomB2;
    endcase
    match     = skip_bom_q && (bom_q != BomDone) && (in_i.byte_value == want);
    phase_eff = match ? bom_q + 2'd1 : bom_q;
    // A mark cut short by end of stream, or a mismatch, gives back the held bytes.
    flush     = (bom_q != BomDone) && (!match || (in_i.end_of_stream && bom_q != BomTwo));
    flush_b0  = flush && ((phase_eff == BomOne) || (phase_eff == BomTwo));
    flush_b1  = flush && (phase_eff == BomTwo);

    t_b0 = flush_b0 ? tok_step(st_q, delim_q, quote_q, BomB0) : tok_t'{st: st_q, default: '0};
    t_b1 = flush_b1 ? tok_step(t_b0.st, delim_q, quote_q, BomB1)
                    : tok_t'{st: t_b0.st, default: '0};
    t_c  = !match ? tok_step(t_b1.st, delim_q, quote_q, in_i.byte_value)
                  : tok_t'{st: t_b1.st, default: '0};

    close_row = in_i.end_of_stream && t_c.st.row_open;

    cand[0] = t_b0.res;  cand_emit[0] = t_b0.emit;
    cand[1] = t_b1.res;  cand_emit[1] = t_b1.emit;
    cand[2] = t_c.res;   cand_emit[2] = t_c.emit;
    cand[3] = '{field_byte: 8'h00, has_byte: 1'b0, end_of_field: 1'b1, end_of_row: 1'b1};
    cand_emit[3] = close_row;

    if (in_i.end_of_stream) begin
      st_d  = '0;
      bom_d = BomNone;
    end else begin
      st_d  = t_c.st;
      bom_d = (bom_q == BomDone) ? BomDone : (match ? bom_q + 2'd1 : BomDone);
    end

    // Pack the emitted results into the front of the buffer.
    cnt_d = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end
    for (int i = 0; i < MaxResults; i++) begin
      if (cand_emit[i]) begin
        res_d[cnt_d[SlotW-1:0]] = cand[i];
        cnt_d = cnt_d + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      bom_q  <= BomNone;
      cnt_q  <= '0;
      head_q <= '0;
    end else if (in_fire) begin
      st_q   <= st_d;
      bom_q  <= bom_d;
      cnt_q  <= cnt_d;
      head_q <= '0;
    end else if (out_fire) begin
      cnt_q  <= cnt_q - CntW'(1);
      head_q <= head_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.field_byte   = res_q[head_q].field_byte;
  assign out_o.has_byte     = res_q[head_q].has_byte;
  assign out_o.end_of_field = res_q[head_q].end_of_field;
  assign out_o.end_of_row   = res_q[head_q].end_of_row;
  assign out_o.last_of_run  = (cnt_q == CntW'(1));

  `CSVT_ASSERT(a_cnt_bound, cnt_q <= CntW'(MaxResults), "result count above buffer depth")
  `CSVT_ASSERT(a_in_only_when_draining, !in_fire || (cnt_q <= CntW'(1)),
               "byte taken while several results are still queued")
  `CSVT_ASSERT(a_row_needs_field, !out_o.valid || !out_o.end_of_row || out_o.end_of_field,
               "end of row without end of field")
  `CSVT_ASSERT(a_byte_zero_when_mark, !out_o.valid || out_o.has_byte || out_o.field_byte == 8'h00,
               "mark result carries a non-zero byte")
  `CSVT_ASSERT_NEXT(a_eos_clears, in_fire && in_i.end_of_stream,
                    st_q == '0 && bom_q == BomNone, "state not cleared after end of stream")

endmodule

`default_nettype wire
